@@ src/sta_pkg.sv @@
// shared types and constants of the section table allocator
`timescale 1ns / 1ps
package sta_pkg;

  localparam int unsigned TableEntries = 64;
  localparam int unsigned PageBytes    = 4096;
  localparam int unsigned PageShift    = $clog2(PageBytes);

  localparam int unsigned AddrW  = 48;
  localparam int unsigned IdW    = 32;
  localparam int unsigned SizeW  = 32;
  localparam int unsigned LenW   = SizeW + 1;
  localparam int unsigned PagesW = LenW - PageShift;

  localparam logic [AddrW-1:0] VirtReset = 48'h0080_0000_0000;

  localparam logic OpCreate = 1'b0;
  localparam logic OpMap    = 1'b1;

  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusMiss   = 2'd1;
  localparam logic [1:0] StatusNoVirt = 2'd2;

  // request travelling down the cell chain
  typedef struct packed {
    logic              valid;
    logic              op;
    logic              done;   // slot taken (create) or match found (map), or map of id 0
    logic [IdW-1:0]    id;     // new id for create, wanted id for map
    logic [AddrW-1:0]  phys;
    logic [PagesW-1:0] pages;
  } tok_t;

endpackage

@@ src/sta_cell.sv @@
// one table slot plus the request register that passes to the next slot
`timescale 1ns / 1ps
module sta_cell
  import sta_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic adv_i,
  input  tok_t tok_i,
  output tok_t tok_o
);

  logic [IdW-1:0]    slot_id_q, slot_id_d;
  logic [AddrW-1:0]  slot_phys_q, slot_phys_d;
  logic [PagesW-1:0] slot_pages_q, slot_pages_d;
  tok_t              tok_q, tok_d;
  logic              tok_valid_q;

  always_comb begin
    slot_id_d    = slot_id_q;
    slot_phys_d  = slot_phys_q;
    slot_pages_d = slot_pages_q;
    tok_d        = tok_i;
    if (tok_i.valid && !tok_i.done) begin
      if (tok_i.op == OpCreate) begin
        if (slot_id_q == '0) begin
          slot_id_d    = tok_i.id;
          slot_phys_d  = tok_i.phys;
          slot_pages_d = tok_i.pages;
          tok_d.done   = 1'b1;
        end
      end else begin
        if (slot_id_q == tok_i.id) begin
          tok_d.done  = 1'b1;
          tok_d.phys  = slot_phys_q;
          tok_d.pages = slot_pages_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_id_q   <= '0;
      tok_valid_q <= 1'b0;
    end else if (adv_i) begin
      slot_id_q   <= slot_id_d;
      tok_valid_q <= tok_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      slot_phys_q  <= slot_phys_d;
      slot_pages_q <= slot_pages_d;
      tok_q        <= tok_d;
    end
  end

  // valid comes from the reset register, the rest from the data register
  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = tok_valid_q;
  end

endmodule

@@ src/sta_result.sv @@
// end of chain: virtual bump pointer and the result register
`timescale 1ns / 1ps
module sta_result
  import sta_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  tok_t              tok_i,
  input  logic              cfg_we_i,
  input  logic [AddrW-1:0]  cfg_wdata_i,
  output logic              out_valid_o,
  output logic [1:0]        status_o,
  output logic [IdW-1:0]    new_id_o,
  output logic [AddrW-1:0]  map_phys_o,
  output logic [AddrW-1:0]  virt_addr_o,
  output logic [LenW-1:0]   byte_length_o
);

  logic [AddrW-1:0] vptr_q, vptr_d;
  logic             out_valid_q;
  logic [1:0]       status_q, status_d;
  logic [IdW-1:0]   new_id_q, new_id_d;
  logic [AddrW-1:0] phys_q, phys_d;
  logic [AddrW-1:0] virt_q, virt_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [LenW-1:0]  len;
  logic [AddrW:0]   vend;

  assign len  = LenW'(tok_i.pages) << PageShift;
  assign vend = {1'b0, vptr_q} + (AddrW + 1)'(len);

  always_comb begin
    vptr_d   = vptr_q;
    status_d = StatusMiss;
    new_id_d = '0;
    phys_d   = '0;
    virt_d   = '0;
    len_d    = '0;
    if (tok_i.op == OpCreate) begin
      if (tok_i.done) begin
        status_d = StatusOk;
        new_id_d = tok_i.id;
      end
    end else if (tok_i.done && tok_i.id != '0) begin
      phys_d = tok_i.phys;
      len_d  = len;
      if (vend[AddrW]) begin
        // would run past the 48-bit space: pointer stays
        status_d = StatusNoVirt;
      end else begin
        status_d = StatusOk;
        virt_d   = vptr_q;
        vptr_d   = vend[AddrW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vptr_q      <= VirtReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        vptr_q <= cfg_wdata_i;
      end else if (adv_i && tok_i.valid) begin
        vptr_q <= vptr_d;
      end
      if (adv_i) begin
        out_valid_q <= tok_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && tok_i.valid) begin
      status_q <= status_d;
      new_id_q <= new_id_d;
      phys_q   <= phys_d;
      virt_q   <= virt_d;
      len_q    <= len_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign new_id_o      = new_id_q;
  assign map_phys_o    = phys_q;
  assign virt_addr_o   = virt_q;
  assign byte_length_o = len_q;

endmodule

@@ src/section_table_allocator.sv @@
// top level of the section table allocator: id counter, slot chain, result stage
`timescale 1ns / 1ps
// Section table allocator. Each request transfer is a create (op 0) or a map (op 1).
// The 64 table slots sit in a chain of cells; a request enters cell 0 and moves one
// cell per clock while the chain advances, so the lowest free slot (create) or lowest
// matching slot (map) claims it. Cell 0 loads on the transfer edge; a result then
// passes the registers of cells 1 to 63 and the result register. Requests follow one
// another down the chain, so while the output is taken the block takes one request per
// cycle; when a result waits on out_stall_i the whole chain holds and in_stall_o rises.
// Ids come from a counter at the chain entry (starting at 1, skipping 0 on wrap)
// that advances on every create, failed or not. Writing cfg_wdata_i with cfg_we_i
// loads the virtual bump pointer; write it only while no request is in flight.
// After reset the table is empty and the pointer is 0x80_0000_0000.
module section_table_allocator
  import sta_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              op_i,
  input  logic [SizeW-1:0]  size_bytes_i,
  input  logic [AddrW-1:0]  phys_base_i,
  input  logic [IdW-1:0]    section_id_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [IdW-1:0]    new_id_o,
  output logic [AddrW-1:0]  map_phys_o,
  output logic [AddrW-1:0]  virt_addr_o,
  output logic [LenW-1:0]   byte_length_o,
  // configuration: virt_base
  input  logic              cfg_we_i,
  input  logic [AddrW-1:0]  cfg_wdata_i
);

  logic           adv;
  logic           accept;
  logic [IdW-1:0] id_cnt_q, id_cnt_d;
  logic [LenW-1:0] size_rnd;
  tok_t           chain [0:TableEntries];

  // the chain moves whenever the result register is free or being drained
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;

  // round up to whole pages
  assign size_rnd = {1'b0, size_bytes_i} + LenW'(PageBytes - 1);

  // entry token; a map of id 0 is marked done so no free slot matches it
  always_comb begin
    chain[0].valid = in_valid_i;
    chain[0].op    = op_i;
    chain[0].done  = (op_i == OpMap) && (section_id_i == '0);
    chain[0].id    = (op_i == OpCreate) ? id_cnt_q : section_id_i;
    chain[0].phys  = phys_base_i;
    chain[0].pages = PagesW'(size_rnd >> PageShift);
  end

  // id counter, never hands out 0
  always_comb begin
    id_cnt_d = id_cnt_q;
    if (accept && op_i == OpCreate) begin
      id_cnt_d = (id_cnt_q == '1) ? IdW'(1) : id_cnt_q + IdW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_cnt_q <= IdW'(1);
    end else begin
      id_cnt_q <= id_cnt_d;
    end
  end

  // one cell per slot
  for (genvar k = 0; k < TableEntries; k++) begin : g_cell
    sta_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .tok_i  (chain[k]),
      .tok_o  (chain[k+1])
    );
  end

  sta_result u_result (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .tok_i         (chain[TableEntries]),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .new_id_o      (new_id_o),
    .map_phys_o    (map_phys_o),
    .virt_addr_o   (virt_addr_o),
    .byte_length_o (byte_length_o)
  );

endmodule

@@ sim/section_table_allocator_tb.sv @@
// self-checking testbench of the section table allocator
`timescale 1ns / 1ps
// Drives create and map requests through the valid/stall request channel and checks
// every result transfer against an in-testbench model of the slot table, the id
// counter and the virtual bump pointer. Directed tasks cover the size and address
// extremes, misses and virtual space exhaustion; random phases follow, each with its
// own virt_base setting. Both sides idle at random except in one phase.
module section_table_allocator_tb;
  import sta_pkg::*;

  localparam int unsigned ChainLatency = TableEntries + 1;
  // longest stretch with no transfer is a drain (latency plus margin) or one
  // result crossing the chain behind a sender gap and a receiver stall
  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned PhaseItems   = 321;

  typedef struct packed {
    logic [1:0]       status;
    logic [IdW-1:0]   new_id;
    logic [AddrW-1:0] map_phys;
    logic [AddrW-1:0] virt_addr;
    logic [LenW-1:0]  byte_length;
  } section_reply_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              op_i;
  logic [SizeW-1:0]  size_bytes_i;
  logic [AddrW-1:0]  phys_base_i;
  logic [IdW-1:0]    section_id_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [1:0]        status_o;
  logic [IdW-1:0]    new_id_o;
  logic [AddrW-1:0]  map_phys_o;
  logic [AddrW-1:0]  virt_addr_o;
  logic [LenW-1:0]   byte_length_o;
  logic              cfg_we_i;
  logic [AddrW-1:0]  cfg_wdata_i;

  // model of the table: slots fill lowest first and are never freed
  logic [IdW-1:0]    slot_ids [TableEntries];
  logic [AddrW-1:0]  slot_bases [TableEntries];
  logic [PagesW-1:0] slot_page_counts [TableEntries];
  logic [IdW-1:0]    id_cursor;
  logic [AddrW-1:0]  virt_cursor;
  int unsigned       live_slots;

  section_reply_t    awaited_replies [$];
  int unsigned       mismatch_count;
  int unsigned       quiet_cycles;
  bit                idling_on;

  section_table_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .size_bytes_i  (size_bytes_i),
    .phys_base_i   (phys_base_i),
    .section_id_i  (section_id_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .new_id_o      (new_id_o),
    .map_phys_o    (map_phys_o),
    .virt_addr_o   (virt_addr_o),
    .byte_length_o (byte_length_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // model of one request: updates table, counter and pointer, returns the result
  function automatic section_reply_t apply_section_request(
    logic op, logic [SizeW-1:0] size, logic [AddrW-1:0] phys, logic [IdW-1:0] sid
  );
    section_reply_t reply;
    logic [LenW-1:0] pages_wide;
    logic [LenW-1:0] length;
    logic [AddrW:0]  end_addr;
    logic [IdW-1:0]  id;
    int              slot;
    int              k;
    reply = '0;
    slot  = -1;
    if (op == OpCreate) begin
      pages_wide = ({1'b0, size} + LenW'(PageBytes - 1)) >> PageShift;
      id = id_cursor;
      // the counter moves on even when the table is full, and skips 0 on wrap
      id_cursor = (id_cursor == '1) ? IdW'(1) : id_cursor + IdW'(1);
      for (k = 0; k < TableEntries; k++) begin
        if (slot < 0 && slot_ids[k] == '0) slot = k;
      end
      if (slot >= 0) begin
        slot_ids[slot]         = id;
        slot_bases[slot]       = phys;
        slot_page_counts[slot] = pages_wide[PagesW-1:0];
        live_slots++;
        reply.status = StatusOk;
        reply.new_id = id;
      end else begin
        reply.status = StatusMiss;
      end
    end else begin
      // id 0 never matches, even though free slots hold 0
      if (sid != '0) begin
        for (k = 0; k < TableEntries; k++) begin
          if (slot < 0 && slot_ids[k] == sid) slot = k;
        end
      end
      if (slot < 0) begin
        reply.status = StatusMiss;
      end else begin
        length   = LenW'(slot_page_counts[slot]) << PageShift;
        end_addr = {1'b0, virt_cursor} + (AddrW + 1)'(length);
        reply.map_phys    = slot_bases[slot];
        reply.byte_length = length;
        if (end_addr[AddrW]) begin
          // no room left: pointer stays put
          reply.status = StatusNoVirt;
        end else begin
          reply.status    = StatusOk;
          reply.virt_addr = virt_cursor;
          virt_cursor     = end_addr[AddrW-1:0];
        end
      end
    end
    return reply;
  endfunction

  function automatic void flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
  endfunction

  function automatic void check_reply();
    section_reply_t want;
    if (awaited_replies.size() == 0) begin
      flag_mismatch("result with nothing pending, status", 64'h0, 64'(status_o));
    end else begin
      want = awaited_replies.pop_front();
      if (status_o !== want.status)
        flag_mismatch("status", 64'(want.status), 64'(status_o));
      if (new_id_o !== want.new_id)
        flag_mismatch("new_id", 64'(want.new_id), 64'(new_id_o));
      if (map_phys_o !== want.map_phys)
        flag_mismatch("map_phys", 64'(want.map_phys), 64'(map_phys_o));
      if (virt_addr_o !== want.virt_addr)
        flag_mismatch("virt_addr", 64'(want.virt_addr), 64'(virt_addr_o));
      if (byte_length_o !== want.byte_length)
        flag_mismatch("byte_length", 64'(want.byte_length), 64'(byte_length_o));
    end
  endfunction

  // result side: check every result transfer, values sampled before the edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_reply();
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result receiver: draws a stall length per result, then takes it
  initial begin : result_sink
    int unsigned hold;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      hold = idling_on ? $urandom_range(0, 10) : 0;
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  function automatic logic [AddrW-1:0] rand_addr();
    return {16'($urandom_range(0, 16'hFFFF)), $urandom()};
  endfunction

  function automatic logic [SizeW-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return SizeW'($urandom_range(0, 3 * PageBytes));
    // page boundaries, one below, on and one above
    if (r < 55) return SizeW'(PageBytes * $urandom_range(0, 16) + $urandom_range(0, 2) - 1);
    if (r < 65) return SizeW'(32'hFFFF_FFFF - $urandom_range(0, PageBytes));
    return SizeW'($urandom());
  endfunction

  // mostly live ids, some id 0, ids not handed out yet and wild values
  function automatic logic [IdW-1:0] pick_map_id();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70 && live_slots > 0) return slot_ids[$urandom_range(0, live_slots - 1)];
    if (r < 78) return '0;
    if (r < 88) return id_cursor + IdW'($urandom_range(0, 5));
    return IdW'($urandom());
  endfunction

  // one request transfer: optional gap, then hold until taken
  task automatic issue_request(
    input logic op, input logic [SizeW-1:0] size,
    input logic [AddrW-1:0] phys, input logic [IdW-1:0] sid
  );
    int unsigned gap;
    gap = idling_on ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    size_bytes_i <= size;
    phys_base_i  <= phys;
    section_id_i <= sid;
    do @(posedge clk_i); while (in_stall_o);
    awaited_replies.push_back(apply_section_request(op, size, phys, sid));
  endtask

  // sender holds off until every result is in and the chain has emptied;
  // a result that never comes ends the run through the watchdog
  task automatic wait_for_replies();
    in_valid_i <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk_i);
    repeat (ChainLatency + 10) @(posedge clk_i);
  endtask

  task automatic write_virt_base(input logic [AddrW-1:0] value);
    wait_for_replies();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    virt_cursor = value;
  endtask

  // zero size, single bytes around a page, the largest size, address extremes
  task automatic test_create_extremes();
    issue_request(OpCreate, '0, '0, '0);
    issue_request(OpCreate, SizeW'(1), '1, '1);
    issue_request(OpCreate, SizeW'(PageBytes - 1), rand_addr(), '0);
    issue_request(OpCreate, SizeW'(PageBytes), rand_addr(), '0);
    issue_request(OpCreate, SizeW'(PageBytes + 1), rand_addr(), '0);
    issue_request(OpCreate, '1, rand_addr(), '0);
    issue_request(OpCreate, SizeW'(32'h8000_0000), rand_addr(), '0);
  endtask

  // every live section, then id 0 and unknown ids
  task automatic test_map_lookup();
    int unsigned k;
    for (k = 0; k < live_slots; k++) issue_request(OpMap, '1, '1, slot_ids[k]);
    issue_request(OpMap, '0, '0, '0);
    issue_request(OpMap, '0, '0, '1);
    issue_request(OpMap, '0, '0, id_cursor);
  endtask

  // pointer at the top of the 48-bit space and at 0
  task automatic test_virt_exhaustion();
    write_virt_base('1);
    issue_request(OpMap, '0, '0, slot_ids[0]);   // zero length still fits
    issue_request(OpMap, '0, '0, slot_ids[1]);   // one page does not
    write_virt_base(48'hFFFF_FFFF_E000);
    issue_request(OpMap, '0, '0, slot_ids[1]);   // ends exactly one page below the top
    issue_request(OpMap, '0, '0, slot_ids[3]);   // would end at 2^48
    issue_request(OpMap, '0, '0, slot_ids[0]);
    write_virt_base('0);
    issue_request(OpMap, '0, '0, slot_ids[5]);   // full 4 GiB length
    issue_request(OpMap, '0, '0, slot_ids[5]);
  endtask

  // random phases, each under its own virt_base; the table fills along the way
  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned n;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_virt_base(VirtReset);
        1: write_virt_base({16'hFFFF, $urandom()});
        2: write_virt_base(rand_addr());
        3: write_virt_base('1);
        4: write_virt_base(AddrW'($urandom()));
        default: write_virt_base({16'hFFFF, $urandom()});
      endcase
      // back-to-back stretch with no idling on either side
      idling_on = (phase != 2);
      for (n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(0, 199) == 0) wait_for_replies();
        if ($urandom_range(0, 99) < 30)
          issue_request(OpCreate, pick_size(), rand_addr(), IdW'($urandom()));
        else
          issue_request(OpMap, SizeW'($urandom()), rand_addr(), pick_map_id());
      end
    end
    idling_on = 1'b1;
  endtask

  initial begin
    int k;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    op_i         = OpCreate;
    size_bytes_i = '0;
    phys_base_i  = '0;
    section_id_i = '0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    for (k = 0; k < TableEntries; k++) begin
      slot_ids[k]         = '0;
      slot_bases[k]       = '0;
      slot_page_counts[k] = '0;
    end
    id_cursor       = IdW'(1);
    virt_cursor     = VirtReset;
    live_slots      = 0;
    mismatch_count  = 0;
    quiet_cycles    = 0;
    idling_on       = 1'b1;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_create_extremes();
    test_map_lookup();
    test_virt_exhaustion();
    test_random_traffic();

    wait_for_replies();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/sta_pkg.sv
src/sta_cell.sv
src/sta_result.sv
src/section_table_allocator.sv
sim/section_table_allocator_tb.sv
